>>> design/mwf_pkg.sv
// ----------------------------------------------------------------------------
// mwf_pkg
// Shared types, constants and helpers for the fifo handoff mutex.
// ----------------------------------------------------------------------------
package mwf_pkg;

  // wait ring depth and significant thread id bits (ID_BITS up to 8)
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef logic [ID_BITS-1:0] id_t;
  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [FILL_W-1:0]  fill_t;

  localparam ptr_t  PTR_LAST  = ptr_t'(QUEUE_DEPTH - 1);
  localparam fill_t FILL_FULL = fill_t'(QUEUE_DEPTH);

  // request kinds
  localparam logic KIND_LOCK   = 1'b0;
  localparam logic KIND_UNLOCK = 1'b1;

  // response status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BUSY = 2'd1,
    ST_PERM = 2'd2,
    ST_FULL = 2'd3
  } rsp_status_t;

  // one response item
  typedef struct packed {
    rsp_status_t status;
    logic        granted;
    logic [7:0]  owner_now;
    logic        woken_valid;
    logic [7:0]  woken_thread;
    logic [4:0]  waiting_count;
    logic [7:0]  request_count;
  } rsp_t;

  // ring pointer advance with wrap
  function automatic ptr_t ptr_inc(input ptr_t p);
    ptr_t r;
    if (p == PTR_LAST) begin
      r = '0;
    end else begin
      r = p + ptr_t'(1);
    end
    return r;
  endfunction

endpackage

>>> design/mwf_if.sv
// ----------------------------------------------------------------------------
// mwf_req_if / mwf_rsp_if
// Valid/ready channels for mutex requests and responses.
// ----------------------------------------------------------------------------
interface mwf_req_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] thread_id;

  modport source (output valid, output kind, output thread_id, input ready);
  modport sink   (input valid, input kind, input thread_id, output ready);
endinterface

interface mwf_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       granted;
  logic [7:0] owner_now;
  logic       woken_valid;
  logic [7:0] woken_thread;
  logic [4:0] waiting_count;
  logic [7:0] request_count;

  modport source (
    output valid, output status, output granted, output owner_now,
    output woken_valid, output woken_thread, output waiting_count,
    output request_count, input ready
  );
  modport sink (
    input valid, input status, input granted, input owner_now,
    input woken_valid, input woken_thread, input waiting_count,
    input request_count, output ready
  );
endinterface

>>> design/mwf_ring_ram.sv
// ----------------------------------------------------------------------------
// mwf_ring_ram
// Simple dual-port ring store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mwf_ring_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/mutex_with_fifo_waiters.sv
// ----------------------------------------------------------------------------
// mutex_with_fifo_waiters
// Hardware mutex with owner id, fifo ring of waiters and a request counter.
// ----------------------------------------------------------------------------
// Timing: a response is registered at the edge that takes the request; an
// unlock that hands over to a waiter goes through the ring read port and the
// handoff state. One request per cycle while rsp is ready; none in S_WAKE.
// Reset (synchronous, rst high): mutex free, ring empty, counter zero,
// output register empty; ring contents are not cleared.
module mutex_with_fifo_waiters (
  input  logic      clk,
  input  logic      rst,
  mwf_req_if.sink   req,
  mwf_rsp_if.source rsp
);

  typedef enum logic {S_IDLE, S_WAKE} state_t;

  state_t         state;
  mwf_pkg::id_t   owner;
  mwf_pkg::ptr_t  head;
  mwf_pkg::ptr_t  tail;
  mwf_pkg::fill_t fill;
  logic [7:0]     pending;
  logic           out_valid;
  mwf_pkg::rsp_t  out_rsp;

  mwf_pkg::id_t   owner_next;
  mwf_pkg::ptr_t  head_next;
  mwf_pkg::ptr_t  tail_next;
  mwf_pkg::fill_t fill_next;
  logic [7:0]     pending_next;
  mwf_pkg::rsp_t  res;
  logic           enq;
  logic           hand;
  logic           acc;
  mwf_pkg::id_t   tid;
  mwf_pkg::id_t   rd_data;

  assign tid = req.thread_id[mwf_pkg::ID_BITS-1:0];
  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign acc = req.valid && req.ready;

  // wait ring storage
  mwf_ring_ram #(
    .DEPTH (mwf_pkg::QUEUE_DEPTH),
    .WIDTH (mwf_pkg::ID_BITS)
  ) u_ring (
    .clk   (clk),
    .we    (acc && enq),
    .waddr (tail),
    .wdata (tid),
    .re    (acc && hand),
    .raddr (head),
    .rdata (rd_data)
  );

  // request decode and next state
  always_comb begin
    owner_next   = owner;
    head_next    = head;
    tail_next    = tail;
    fill_next    = fill;
    pending_next = pending;
    enq          = 1'b0;
    hand         = 1'b0;
    res          = '0;
    res.status   = mwf_pkg::ST_OK;
    if (tid == '0) begin
      res.status = mwf_pkg::ST_PERM;
    end else if (req.kind == mwf_pkg::KIND_LOCK) begin
      if (pending != mwf_pkg::COUNT_MAX) begin
        pending_next = pending + 8'd1;
      end
      priority if (owner == '0) begin
        owner_next  = tid;
        res.granted = 1'b1;
      end else if (owner == tid) begin
        res.status = mwf_pkg::ST_BUSY;
      end else if (fill == mwf_pkg::FILL_FULL) begin
        res.status = mwf_pkg::ST_FULL;
      end else begin
        enq       = 1'b1;
        tail_next = mwf_pkg::ptr_inc(tail);
        fill_next = fill + mwf_pkg::fill_t'(1);
      end
    end else begin
      if (pending != 8'd0) begin
        pending_next = pending - 8'd1;
      end
      priority if (owner != tid) begin
        res.status = mwf_pkg::ST_PERM;
      end else if (fill == '0) begin
        owner_next = '0;
      end else begin
        hand      = 1'b1;
        head_next = mwf_pkg::ptr_inc(head);
        fill_next = fill - mwf_pkg::fill_t'(1);
      end
    end
    res.owner_now     = 8'(owner_next);
    res.waiting_count = 5'(fill_next);
    res.request_count = pending_next;
  end

  // control state and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      owner     <= '0;
      head      <= '0;
      tail      <= '0;
      fill      <= '0;
      pending   <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            owner   <= owner_next;
            head    <= head_next;
            tail    <= tail_next;
            fill    <= fill_next;
            pending <= pending_next;
            if (hand) begin
              // any earlier response leaves at this edge
              out_valid <= 1'b0;
              state     <= S_WAKE;
            end else begin
              out_valid <= 1'b1;
              out_rsp   <= res;
            end
          end else if (rsp.ready) begin
            out_valid <= 1'b0;
          end
        end
        S_WAKE: begin
          // ring data for the oldest waiter is now available
          owner                 <= rd_data;
          out_valid             <= 1'b1;
          out_rsp.status        <= mwf_pkg::ST_OK;
          out_rsp.granted       <= 1'b0;
          out_rsp.owner_now     <= 8'(rd_data);
          out_rsp.woken_valid   <= 1'b1;
          out_rsp.woken_thread  <= 8'(rd_data);
          out_rsp.waiting_count <= 5'(fill);
          out_rsp.request_count <= pending;
          state                 <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // response port
  assign rsp.valid         = out_valid;
  assign rsp.status        = out_rsp.status;
  assign rsp.granted       = out_rsp.granted;
  assign rsp.owner_now     = out_rsp.owner_now;
  assign rsp.woken_valid   = out_rsp.woken_valid;
  assign rsp.woken_thread  = out_rsp.woken_thread;
  assign rsp.waiting_count = out_rsp.waiting_count;
  assign rsp.request_count = out_rsp.request_count;

  // ring never holds more than its depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= mwf_pkg::FILL_FULL)
    else $error("wait ring fill beyond depth");

  // handoff state only follows an accepted handoff request
  a_wake_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(state == S_WAKE) |-> $past(acc && hand))
    else $error("handoff state entered without handoff transfer");

  // a woken thread becomes the owner and the status is ok
  a_woken_owner: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_rsp.woken_valid) |->
      (out_rsp.owner_now == out_rsp.woken_thread
       && out_rsp.status == mwf_pkg::ST_OK && out_rsp.owner_now != 8'd0))
    else $error("woken thread is not the reported owner");

  // an immediate grant always leaves a nonzero owner
  a_grant_owner: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_rsp.granted) |->
      (out_rsp.owner_now != 8'd0 && out_rsp.status == mwf_pkg::ST_OK))
    else $error("grant without owner");

endmodule
